// ===== rtl/pasm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pasm_pkg;

  // operand and result store sizes
  localparam int EXP_RANGE = 256;
  localparam int RES_RANGE = 2 * EXP_RANGE - 1;

  // default number of multiply cells in the row
  localparam int NCELL_DEF = 16;

  // field widths
  localparam int COEF_W = 32;
  localparam int EXP_W  = 8;
  localparam int REXP_W = 9;
  localparam int CNT_W  = 9;
  localparam int MODE_W = 2;
  localparam int CMD_W  = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

  // operation modes
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // per-cycle control of the cell row
  typedef struct packed {
    logic shift;
    logic mul_en;
    logic clr;
    logic unload;
  } pasm_cell_ctl_t;

  // one result store entry
  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic              pres;
  } pasm_rterm_t;

endpackage

`default_nettype wire

// ===== rtl/pasm_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// command channel
interface pasm_in_if;
  import pasm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [COEF_W-1:0] term_coef;
  logic [EXP_W-1:0]         term_exp;
  modport source (output valid, output cmd, output term_coef, output term_exp,
                  input ready);
  modport sink (input valid, input cmd, input term_coef, input term_exp,
                output ready);
endinterface

// result channel
interface pasm_out_if;
  import pasm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] res_coef;
  logic [REXP_W-1:0]        res_exp;
  logic                     last_term;
  logic                     no_terms;
  logic [CNT_W-1:0]         term_count;
  modport source (output valid, output res_coef, output res_exp, output last_term,
                  output no_terms, output term_count, input ready);
  modport sink (input valid, input res_coef, input res_exp, input last_term,
                input no_terms, input term_count, output ready);
endinterface

// mode register write channel
interface pasm_cfg_if;
  import pasm_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] op_mode;
  modport source (output valid, output op_mode, input ready);
  modport sink (input valid, input op_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/pasm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pasm_cell
  import pasm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pasm_cell_ctl_t    ctl,
  input  logic [COEF_W-1:0] a_val,
  input  logic              a_ok,
  input  logic [COEF_W-1:0] b_in,
  input  logic              pb_in,
  output logic [COEF_W-1:0] b_out,
  output logic              pb_out,
  input  logic [COEF_W-1:0] acc_in,
  input  logic              pres_in,
  output logic [COEF_W-1:0] acc_out,
  output logic              pres_out
);

  logic [COEF_W-1:0] b_r;
  logic              pb_r;
  logic [COEF_W-1:0] prod_r;
  logic              pv_r;
  logic [COEF_W-1:0] acc_r;
  logic              pres_r;

  // second operand coefficient moves one cell per step
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      b_r  <= b_in;
      pb_r <= pb_in;
    end
  end

  // product register, wraps to 32 bits
  always_ff @(posedge clk) begin
    prod_r <= a_val * b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.mul_en & a_ok & pb_r;
    end
  end

  // accumulator, cleared per compute, shifted out toward cell 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= 1'b0;
      acc_r  <= '0;
    end else if (ctl.clr) begin
      pres_r <= 1'b0;
      acc_r  <= '0;
    end else if (ctl.unload) begin
      pres_r <= pres_in;
      acc_r  <= acc_in;
    end else if (pv_r) begin
      pres_r <= 1'b1;
      acc_r  <= acc_r + prod_r;
    end
  end

  assign b_out    = b_r;
  assign pb_out   = pb_r;
  assign acc_out  = acc_r;
  assign pres_out = pres_r;

endmodule

`default_nettype wire

// ===== rtl/pasm_cell_row.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pasm_cell_row
  import pasm_pkg::*;
#(
  parameter int NCELL = NCELL_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pasm_cell_ctl_t    ctl,
  input  logic [COEF_W-1:0] a_val,
  input  logic              a_ok,
  input  logic [COEF_W-1:0] b_in,
  input  logic              pb_in,
  output logic [COEF_W-1:0] acc_out,
  output logic              pres_out
);

  logic [COEF_W-1:0] b_ch    [NCELL+1];
  logic              pb_ch   [NCELL+1];
  logic [COEF_W-1:0] acc_ch  [NCELL+1];
  logic              pres_ch [NCELL+1];

  // chain ends
  assign b_ch[0]        = b_in;
  assign pb_ch[0]       = pb_in;
  assign acc_ch[NCELL]  = '0;
  assign pres_ch[NCELL] = 1'b0;

  // cell c accumulates result coefficient k0 + c
  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    pasm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .a_val    (a_val),
      .a_ok     (a_ok),
      .b_in     (b_ch[c]),
      .pb_in    (pb_ch[c]),
      .b_out    (b_ch[c+1]),
      .pb_out   (pb_ch[c+1]),
      .acc_in   (acc_ch[c+1]),
      .pres_in  (pres_ch[c+1]),
      .acc_out  (acc_ch[c]),
      .pres_out (pres_ch[c])
    );
  end

  assign acc_out  = acc_ch[0];
  assign pres_out = pres_ch[0];

endmodule

`default_nettype wire

// ===== rtl/polynomial_add_sub_mult.sv =====
// load: each term beat passes through the load write state; read: an issue and a check state per result entry scanned
// compute add/sub: a sweep over all RES_RANGE result entries, one result entry per cycle through the store port
// compute multiply: ceil(RES_RANGE/NCELL) blocks, each a run of the cell row stepping over every
//   first-operand exponent, then a drain, then an unload of the cells into the result store
// one command in flight at a time; a finished result waits in the output register
// reset clears control, presence bits and mode at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module polynomial_add_sub_mult
  import pasm_pkg::*;
#(
  parameter int NCELL = NCELL_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pasm_in_if.sink    in_bus,
  pasm_out_if.source out_bus,
  pasm_cfg_if.sink   cfg_bus
);

  localparam int AW     = EXP_W;
  localparam int RW     = REXP_W;
  localparam int KW     = RW + 1;
  localparam int SW     = $clog2(NCELL + EXP_RANGE);
  localparam int UW     = $clog2(NCELL);
  localparam int S_LAST = NCELL + EXP_RANGE - 2;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LD_WR    = 4'd1;
  localparam logic [3:0] ST_ADD_RUN  = 4'd2;
  localparam logic [3:0] ST_ADD_END  = 4'd3;
  localparam logic [3:0] ST_MUL_RUN  = 4'd4;
  localparam logic [3:0] ST_MUL_DRN  = 4'd5;
  localparam logic [3:0] ST_MUL_UNLD = 4'd6;
  localparam logic [3:0] ST_FIN      = 4'd7;
  localparam logic [3:0] ST_RD_ISS   = 4'd8;
  localparam logic [3:0] ST_RD_CHK   = 4'd9;
  localparam logic [3:0] ST_EMIT     = 4'd10;

  localparam logic PH_LOAD  = 1'b0;
  localparam logic PH_READY = 1'b1;

  // control state
  logic [3:0]        state_r, state_nxt;
  logic              phase_r, phase_nxt;
  logic [MODE_W-1:0] op_mode_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [RW-1:0]     pos_r, pos_nxt;
  logic [RW-1:0]     k_r, k_nxt;
  logic [KW-1:0]     k0_r, k0_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic [1:0]        dr_r, dr_nxt;
  logic [UW-1:0]     u_r, u_nxt;
  logic              out_v_r;

  // load capture
  logic              ld_b_r, ld_b_nxt;
  logic [AW-1:0]     ld_exp_r, ld_exp_nxt;
  logic [COEF_W-1:0] ld_coef_r, ld_coef_nxt;

  // pending result
  logic [COEF_W-1:0] res_coef_r, res_coef_nxt;
  logic [RW-1:0]     res_exp_r, res_exp_nxt;
  logic              res_last_r, res_last_nxt;
  logic              res_none_r, res_none_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;

  // operand stores
  logic [EXP_RANGE-1:0] pa_r, pb_r;
  logic [COEF_W-1:0]    a_mem [EXP_RANGE];
  logic [COEF_W-1:0]    b_mem [EXP_RANGE];
  logic [COEF_W-1:0]    a_rd, b_rd;
  logic [AW-1:0]        a_raddr, b_raddr;
  logic [COEF_W-1:0]    ld_sum;

  // result store
  pasm_rterm_t   r_mem [RES_RANGE];
  pasm_rterm_t   r_rd;
  pasm_rterm_t   r_wdata;
  logic          r_we;
  logic [RW-1:0] r_waddr;

  // add sweep pipeline
  logic          sw_v_r, sw_fa_r, sw_fb_r;
  logic [RW-1:0] sw_k_r;
  logic          sw_fa, sw_fb;
  logic [COEF_W-1:0] sw_bterm;

  // multiply feed pipeline
  int                m_i, i_i;
  logic              mi_bok, mi_aok;
  logic              mi_v_r, mi_bok_r, mi_aok_r;
  logic [COEF_W-1:0] a_q_r;
  logic              a_ok_q_r, mul_q_r;
  logic              cell_clr;
  pasm_cell_ctl_t    cell_ctl;
  logic [COEF_W-1:0] acc_out;
  logic              pres_out;
  logic [KW-1:0]     ul_addr;

  logic in_fire, clear_all, emit_go;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_fire       = in_bus.valid & in_bus.ready;
  assign emit_go       = (state_r == ST_EMIT) && (!out_v_r || out_bus.ready);

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r <= MODE_ADD;
    end else if (cfg_bus.valid) begin
      op_mode_r <= cfg_bus.op_mode;
    end
  end

  // multiply step indexes: second operand exponent m, first operand exponent i
  always_comb begin
    m_i    = int'(k0_r) + NCELL - 1 - int'(s_r);
    i_i    = int'(s_r) + 1 - NCELL;
    mi_bok = (m_i >= 0 && m_i < EXP_RANGE) ? pb_r[m_i[AW-1:0]] : 1'b0;
    mi_aok = (i_i >= 0 && i_i < EXP_RANGE) ? pa_r[i_i[AW-1:0]] : 1'b0;
  end

  // add sweep flags
  always_comb begin
    sw_fa = (int'(k_r) < EXP_RANGE) && pa_r[k_r[AW-1:0]] && (op_mode_r != MODE_NONE);
    sw_fb = (int'(k_r) < EXP_RANGE) && pb_r[k_r[AW-1:0]] && (op_mode_r != MODE_NONE);
  end

  // operand read addresses
  always_comb begin
    case (state_r)
      ST_IDLE: begin
        a_raddr = in_bus.term_exp;
        b_raddr = in_bus.term_exp;
      end
      ST_ADD_RUN: begin
        a_raddr = k_r[AW-1:0];
        b_raddr = k_r[AW-1:0];
      end
      ST_MUL_RUN: begin
        a_raddr = i_i[AW-1:0];
        b_raddr = m_i[AW-1:0];
      end
      default: begin
        a_raddr = ld_exp_r;
        b_raddr = ld_exp_r;
      end
    endcase
  end

  // merged coefficient of a loaded term
  always_comb begin
    if (ld_b_r) begin
      ld_sum = (pb_r[ld_exp_r] ? b_rd : '0) + ld_coef_r;
    end else begin
      ld_sum = (pa_r[ld_exp_r] ? a_rd : '0) + ld_coef_r;
    end
  end

  // operand memories
  always_ff @(posedge clk) begin
    if (state_r == ST_LD_WR && !ld_b_r) begin
      a_mem[ld_exp_r] <= ld_sum;
    end
    a_rd <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LD_WR && ld_b_r) begin
      b_mem[ld_exp_r] <= ld_sum;
    end
    b_rd <= b_mem[b_raddr];
  end

  // presence bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r <= '0;
      pb_r <= '0;
    end else if (clear_all) begin
      pa_r <= '0;
      pb_r <= '0;
    end else if (state_r == ST_LD_WR) begin
      if (ld_b_r) begin
        pb_r[ld_exp_r] <= 1'b1;
      end else begin
        pa_r[ld_exp_r] <= 1'b1;
      end
    end
  end

  // add sweep and multiply feed pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_v_r   <= 1'b0;
      mi_v_r   <= 1'b0;
      mul_q_r  <= 1'b0;
    end else begin
      sw_v_r   <= (state_r == ST_ADD_RUN);
      mi_v_r   <= (state_r == ST_MUL_RUN);
      mul_q_r  <= mi_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sw_k_r   <= k_r;
    sw_fa_r  <= sw_fa;
    sw_fb_r  <= sw_fb;
    mi_bok_r <= mi_bok;
    mi_aok_r <= mi_aok;
    a_q_r    <= a_rd;
    a_ok_q_r <= mi_aok_r;
  end

  // cell row
  always_comb begin
    cell_ctl.shift  = mi_v_r;
    cell_ctl.mul_en = mul_q_r;
    cell_ctl.clr    = cell_clr;
    cell_ctl.unload = (state_r == ST_MUL_UNLD);
  end

  pasm_cell_row #(
    .NCELL (NCELL)
  ) u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cell_ctl),
    .a_val    (a_q_r),
    .a_ok     (a_ok_q_r),
    .b_in     (b_rd),
    .pb_in    (mi_bok_r),
    .acc_out  (acc_out),
    .pres_out (pres_out)
  );

  // result store write port
  assign ul_addr  = k0_r + KW'(u_r);
  assign sw_bterm = (op_mode_r == MODE_SUB) ? (COEF_W'(0) - b_rd) : b_rd;

  always_comb begin
    r_we    = 1'b0;
    r_waddr = sw_k_r;
    r_wdata.coef = (sw_fa_r ? a_rd : '0) + (sw_fb_r ? sw_bterm : '0);
    r_wdata.pres = sw_fa_r | sw_fb_r;
    if (sw_v_r) begin
      r_we = 1'b1;
    end else if (state_r == ST_MUL_UNLD && int'(ul_addr) < RES_RANGE) begin
      r_we         = 1'b1;
      r_waddr      = ul_addr[RW-1:0];
      r_wdata.coef = acc_out;
      r_wdata.pres = pres_out;
    end
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      r_mem[r_waddr] <= r_wdata;
    end
    r_rd <= r_mem[pos_r];
  end

  // command sequencer
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    remain_nxt   = remain_r;
    pos_nxt      = pos_r;
    k_nxt        = k_r;
    k0_nxt       = k0_r;
    s_nxt        = s_r;
    dr_nxt       = dr_r;
    u_nxt        = u_r;
    ld_b_nxt     = ld_b_r;
    ld_exp_nxt   = ld_exp_r;
    ld_coef_nxt  = ld_coef_r;
    res_coef_nxt = res_coef_r;
    res_exp_nxt  = res_exp_r;
    res_last_nxt = res_last_r;
    res_none_nxt = res_none_r;
    res_cnt_nxt  = res_cnt_r;
    cell_clr     = 1'b0;
    clear_all    = 1'b0;

    // count present entries as they are written
    if (r_we && r_wdata.pres) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_bus.cmd)
            CMD_LOAD_A, CMD_LOAD_B: begin
              ld_b_nxt    = (in_bus.cmd == CMD_LOAD_B);
              ld_exp_nxt  = in_bus.term_exp;
              ld_coef_nxt = in_bus.term_coef;
              state_nxt   = ST_LD_WR;
            end
            CMD_COMPUTE: begin
              cnt_nxt = '0;
              if (op_mode_r == MODE_MUL) begin
                cell_clr  = 1'b1;
                k0_nxt    = '0;
                s_nxt     = '0;
                state_nxt = ST_MUL_RUN;
              end else begin
                k_nxt     = '0;
                state_nxt = ST_ADD_RUN;
              end
            end
            default: begin
              if (phase_r == PH_READY && remain_r != '0) begin
                state_nxt = ST_RD_ISS;
              end else begin
                res_coef_nxt = '0;
                res_exp_nxt  = '0;
                res_last_nxt = 1'b0;
                res_none_nxt = 1'b1;
                res_cnt_nxt  = '0;
                clear_all    = 1'b1;
                state_nxt    = ST_EMIT;
              end
            end
          endcase
        end
      end
      ST_LD_WR: begin
        state_nxt = ST_IDLE;
      end
      ST_ADD_RUN: begin
        k_nxt = k_r + 1'b1;
        if (k_r == RW'(RES_RANGE - 1)) begin
          state_nxt = ST_ADD_END;
        end
      end
      ST_ADD_END: begin
        state_nxt = ST_FIN;
      end
      ST_MUL_RUN: begin
        s_nxt = s_r + 1'b1;
        if (s_r == SW'(S_LAST)) begin
          dr_nxt    = '0;
          state_nxt = ST_MUL_DRN;
        end
      end
      ST_MUL_DRN: begin
        dr_nxt = dr_r + 1'b1;
        if (dr_r == 2'd2) begin
          u_nxt     = '0;
          state_nxt = ST_MUL_UNLD;
        end
      end
      ST_MUL_UNLD: begin
        u_nxt = u_r + 1'b1;
        if (u_r == UW'(NCELL - 1)) begin
          k0_nxt = k0_r + KW'(NCELL);
          if (int'(k0_r) + NCELL >= RES_RANGE) begin
            state_nxt = ST_FIN;
          end else begin
            s_nxt     = '0;
            state_nxt = ST_MUL_RUN;
          end
        end
      end
      ST_FIN: begin
        res_coef_nxt = '0;
        res_exp_nxt  = '0;
        res_last_nxt = 1'b0;
        res_none_nxt = 1'b0;
        res_cnt_nxt  = cnt_r;
        phase_nxt    = PH_READY;
        pos_nxt      = RW'(RES_RANGE - 1);
        remain_nxt   = cnt_r;
        state_nxt    = ST_EMIT;
      end
      ST_RD_ISS: begin
        state_nxt = ST_RD_CHK;
      end
      ST_RD_CHK: begin
        pos_nxt = pos_r - 1'b1;
        if (r_rd.pres) begin
          res_coef_nxt = r_rd.coef;
          res_exp_nxt  = pos_r;
          res_last_nxt = (remain_r == CNT_W'(1));
          res_none_nxt = 1'b0;
          res_cnt_nxt  = '0;
          remain_nxt   = remain_r - 1'b1;
          clear_all    = (remain_r == CNT_W'(1));
          state_nxt    = ST_EMIT;
        end else begin
          state_nxt = ST_RD_ISS;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (clear_all) begin
      phase_nxt  = PH_LOAD;
      remain_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_LOAD;
      cnt_r    <= '0;
      remain_r <= '0;
      pos_r    <= RW'(RES_RANGE - 1);
      k_r      <= '0;
      k0_r     <= '0;
      s_r      <= '0;
      dr_r     <= '0;
      u_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      remain_r <= remain_nxt;
      pos_r    <= pos_nxt;
      k_r      <= k_nxt;
      k0_r     <= k0_nxt;
      s_r      <= s_nxt;
      dr_r     <= dr_nxt;
      u_r      <= u_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_b_r     <= ld_b_nxt;
    ld_exp_r   <= ld_exp_nxt;
    ld_coef_r  <= ld_coef_nxt;
    res_coef_r <= res_coef_nxt;
    res_exp_r  <= res_exp_nxt;
    res_last_r <= res_last_nxt;
    res_none_r <= res_none_nxt;
    res_cnt_r  <= res_cnt_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit_go) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_bus.res_coef   <= res_coef_r;
      out_bus.res_exp    <= res_exp_r;
      out_bus.last_term  <= res_last_r;
      out_bus.no_terms   <= res_none_r;
      out_bus.term_count <= res_cnt_r;
    end
  end

  assign out_bus.valid = out_v_r;

  // checks
  a_last_none_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_bus.no_terms && out_bus.last_term))
    else $error("beat flags both last term and no terms");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_CHK && r_rd.pres && remain_r == CNT_W'(1))
      |=> (phase_r == PH_LOAD && pa_r == '0 && pb_r == '0))
    else $error("final read did not clear the stores");

  a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_CHK && !r_rd.pres) |=> (pos_r == $past(pos_r) - 1'b1))
    else $error("read scan skipped an entry");

  a_fin_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (phase_r == PH_READY && remain_r == $past(cnt_r)))
    else $error("compute end did not arm the read phase");

endmodule

`default_nettype wire
